FILE: rtl/core/spq_pkg.sv
// Package for the stable priority queue: sizes, entry layout, status and
// operation codes. No dependencies; used by every file under rtl/core but spq_ram.
`default_nettype none

package spq_pkg;

  // Queue depth and the widths that follow from it
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int ITEM_W  = 16;
  localparam int KIND_W  = 8;
  localparam int PRIO_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  // One queued entry as held in the store
  typedef struct packed {
    logic [ITEM_W-1:0]        item;
    logic [KIND_W-1:0]        kind;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/core/spq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue: sequencer, entry store and result register.
// Depends on spq_pkg and spq_ram.
`default_nettype none

// Bounded min-first priority queue of up to spq_pkg::DEPTH entries, kept sorted
// in a RAM; equal priorities leave in arrival order. One operation is taken at a
// time and in_stall stays high until its result is registered. Each operation
// is paced by the single read and single write port of the entry RAM: one pass
// reads every queued entry through one priority/handle comparator, and a second
// pass moves the entries behind the insert or remove slot by one place. Rejected
// inserts and removes from an empty queue finish after the scan or at once.
// The result sits in an output register, so the next operation can start while
// it waits to be taken.
module stable_priority_queue (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_op,
  input  wire logic [spq_pkg::ITEM_W-1:0]            in_item_id,
  input  wire logic [spq_pkg::KIND_W-1:0]            in_kind,
  input  wire logic signed [spq_pkg::PRIO_W-1:0]     in_priority_req,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [spq_pkg::STAT_W-1:0]                 out_status,
  output logic [spq_pkg::OCNT_W-1:0]                 out_count,
  output logic [spq_pkg::ITEM_W-1:0]                 out_item_id,
  output logic [spq_pkg::KIND_W-1:0]                 out_kind,
  output logic signed [spq_pkg::PRIO_W-1:0]          out_priority
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_RM0   = 3'd4;
  localparam logic [2:0] S_RMSH  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int IW = spq_pkg::IDX_W;
  localparam int CW = spq_pkg::CNT_W;

  // Control state
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working registers
  spq_pkg::entry_t             new_r, new_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [IW-1:0]               pos_r, pos_nxt;
  logic                        found_r, found_nxt;
  logic                        dup_r, dup_nxt;
  logic [spq_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  spq_pkg::entry_t             res_entry_r, res_entry_nxt;

  // Output register
  logic [spq_pkg::STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [spq_pkg::OCNT_W-1:0]      out_count_r, out_count_nxt;
  spq_pkg::entry_t                 out_entry_r, out_entry_nxt;

  // RAM port
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [IW-1:0]   ram_raddr;
  spq_pkg::entry_t ram_wdata;
  spq_pkg::entry_t ram_rdata;
  logic [spq_pkg::ENTRY_W-1:0] ram_rdata_raw;

  // Shared comparator results
  logic          hit;
  logic          gt;
  logic          dup_now;
  logic          last;
  logic          full;
  logic [CW-1:0] cnt_m1;

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (spq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = spq_pkg::entry_t'(ram_rdata_raw);

  // One handle compare and one signed priority compare, used every scan cycle
  assign hit     = (ram_rdata.item == new_r.item);
  assign gt      = ($signed(ram_rdata.prio) > $signed(new_r.prio));
  assign dup_now = dup_r | hit;
  assign cnt_m1  = cnt_r - CW'(1);
  assign last    = (CW'(idx_r) == cnt_m1);
  assign full    = (cnt_r == CW'(spq_pkg::DEPTH));

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_item_id  = out_entry_r.item;
  assign out_kind     = out_entry_r.kind;
  assign out_priority = out_entry_r.prio;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    new_nxt        = new_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    dup_nxt        = dup_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_entry_nxt  = out_entry_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = '0;

    // Drop the held result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.item   = in_item_id;
          new_nxt.kind   = in_kind;
          new_nxt.prio   = in_priority_req;
          res_status_nxt = spq_pkg::ST_OK;
          res_entry_nxt  = '0;
          idx_nxt        = '0;
          pos_nxt        = '0;
          found_nxt      = 1'b0;
          dup_nxt        = 1'b0;
          ram_raddr      = '0;
          if (in_op == spq_pkg::OP_REMOVE) begin
            if (cnt_r == '0) begin
              res_status_nxt = spq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_RM0;
            end
          end else if (in_item_id == '0) begin
            res_status_nxt = spq_pkg::ST_REJECT;
            state_nxt      = S_DONE;
          end else if (cnt_r == '0) begin
            state_nxt = S_INS;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // Look for a duplicate handle and the first entry with a larger priority value
      S_SCAN: begin
        dup_nxt = dup_now;
        if (!found_r && gt) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        if (last) begin
          if (dup_now) begin
            res_status_nxt = spq_pkg::ST_REJECT;
            state_nxt      = S_DONE;
          end else if (full) begin
            res_status_nxt = spq_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else if (!(found_r || gt)) begin
            pos_nxt   = IW'(cnt_r);
            state_nxt = S_INS;
          end else begin
            pos_nxt   = found_r ? pos_r : idx_r;
            idx_nxt   = IW'(cnt_m1);
            ram_raddr = IW'(cnt_m1);
            state_nxt = S_SHIFT;
          end
        end else begin
          idx_nxt   = idx_r + IW'(1);
          ram_raddr = idx_r + IW'(1);
        end
      end

      // Move entries from the tail down to the insert slot up by one
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + IW'(1);
        ram_wdata = ram_rdata;
        if (idx_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          idx_nxt   = idx_r - IW'(1);
          ram_raddr = idx_r - IW'(1);
        end
      end

      // Store the new entry
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = new_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end

      // Capture the head entry
      S_RM0: begin
        res_entry_nxt = ram_rdata;
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = IW'(1);
          ram_raddr = IW'(1);
          state_nxt = S_RMSH;
        end
      end

      // Move the remaining entries down by one
      S_RMSH: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - IW'(1);
        ram_wdata = ram_rdata;
        if (last) begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          ram_raddr = idx_r + IW'(1);
        end
      end

      // Hand the result to the output register when it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = spq_pkg::OCNT_W'(cnt_r);
          out_entry_nxt  = res_entry_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    new_r        <= new_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    dup_r        <= dup_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_entry_r  <= out_entry_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/spq_checker.sv
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue.
`default_nettype none

module spq_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               in_op,
  input wire logic [spq_pkg::ITEM_W-1:0]         in_item_id,
  input wire logic [spq_pkg::KIND_W-1:0]         in_kind,
  input wire logic signed [spq_pkg::PRIO_W-1:0]  in_priority_req,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [spq_pkg::STAT_W-1:0]         out_status,
  input wire logic [spq_pkg::OCNT_W-1:0]         out_count,
  input wire logic [spq_pkg::ITEM_W-1:0]         out_item_id,
  input wire logic [spq_pkg::KIND_W-1:0]         out_kind,
  input wire logic signed [spq_pkg::PRIO_W-1:0]  out_priority
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_count)
      && $stable(out_item_id) && $stable(out_kind) && $stable(out_priority))
    else $error("stalled result changed");

  // One transaction at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // An empty remove reports an empty queue
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_EMPTY |-> out_count == '0)
    else $error("empty status with nonzero count");

  // Only a successful remove carries entry fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != spq_pkg::ST_OK |->
      out_item_id == '0 && out_kind == '0 && out_priority == '0)
    else $error("entry fields on a failed transaction");

  // A full report means the queue holds its full depth
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spq_pkg::ST_FULL |->
      out_count == spq_pkg::OCNT_W'(spq_pkg::DEPTH))
    else $error("full status with wrong count");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

FILE: tb/sv/stable_priority_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stable_priority_queue: directed and random insert/remove
// traffic against a sorted-store predictor. Depends on spq_pkg and the RTL top level.

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int N_ITEMS      = 1750;
  localparam int LIMIT_CYCLES = 600000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_ITEMS   = 200;
  localparam int MAX_PRINTS   = 50;

  // One pending transaction for the input channel; a pause entry waits for every outstanding result
  typedef struct {
    logic                     op;
    logic [ITEM_W-1:0]        item_id;
    logic [KIND_W-1:0]        kind;
    logic signed [PRIO_W-1:0] prio;
    bit                       pause;
  } queue_op_t;

  // One expected result transaction
  typedef struct {
    logic [STAT_W-1:0]        status;
    logic [OCNT_W-1:0]        count;
    logic [ITEM_W-1:0]        item_id;
    logic [KIND_W-1:0]        kind;
    logic signed [PRIO_W-1:0] prio;
  } queue_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_op = OP_INSERT;
  logic [ITEM_W-1:0]        in_item_id = '0;
  logic [KIND_W-1:0]        in_kind = '0;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic                     out_stall = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [OCNT_W-1:0]        out_count;
  logic [ITEM_W-1:0]        out_item_id;
  logic [KIND_W-1:0]        out_kind;
  logic signed [PRIO_W-1:0] out_priority;

  stable_priority_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_item_id      (in_item_id),
    .in_kind         (in_kind),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_item_id     (out_item_id),
    .out_kind        (out_kind),
    .out_priority    (out_priority)
  );

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];
  queue_op_t     cur_op;
  int            item_total;
  int            mismatches;
  int            cycle_count;

  // Predicted contents of the sorted store
  entry_t        sorted_store[DEPTH];
  int            stored_count;

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one operation to the predicted store and return its result
  function automatic queue_result_t apply_queue_op(input queue_op_t t);
    queue_result_t r;
    bit            dup;
    int            pos;
    r = '{status: ST_OK, count: '0, item_id: '0, kind: '0, prio: '0};
    if (t.op == OP_INSERT) begin
      dup = 1'b0;
      for (int i = 0; i < stored_count; i++) begin
        if (sorted_store[i].item == t.item_id) dup = 1'b1;
      end
      if (t.item_id == '0 || dup) begin
        r.status = ST_REJECT;
      end else if (stored_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // land after every entry of lower or equal priority value
        pos = 0;
        while (pos < stored_count && sorted_store[pos].prio <= t.prio) pos++;
        for (int i = stored_count; i > pos; i--) sorted_store[i] = sorted_store[i-1];
        sorted_store[pos].item = t.item_id;
        sorted_store[pos].kind = t.kind;
        sorted_store[pos].prio = t.prio;
        stored_count++;
      end
    end else begin
      if (stored_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.item_id = sorted_store[0].item;
        r.kind    = sorted_store[0].kind;
        r.prio    = sorted_store[0].prio;
        for (int i = 1; i < stored_count; i++) sorted_store[i-1] = sorted_store[i];
        stored_count--;
      end
    end
    r.count = stored_count[OCNT_W-1:0];
    return r;
  endfunction

  function automatic bit in_tail_phase();
    return pending_ops.size() < TAIL_ITEMS;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic add_insert(input logic [ITEM_W-1:0] id, input logic [KIND_W-1:0] k,
                            input logic signed [PRIO_W-1:0] p);
    pending_ops.push_back('{op: OP_INSERT, item_id: id, kind: k, prio: p, pause: 1'b0});
    item_total++;
  endtask

  task automatic add_remove();
    queue_op_t t;
    // payload of a remove is don't-care to the block; randomize it anyway
    t.op      = OP_REMOVE;
    t.item_id = ITEM_W'($urandom_range(0, 65535));
    t.kind    = KIND_W'($urandom_range(0, 255));
    t.prio    = $urandom();
    t.pause   = 1'b0;
    pending_ops.push_back(t);
    item_total++;
  endtask

  task automatic add_pause();
    pending_ops.push_back('{op: OP_INSERT, item_id: '0, kind: '0, prio: '0, pause: 1'b1});
  endtask

  // Handles mostly from a small pool so duplicates meet queued entries
  function automatic logic [ITEM_W-1:0] pick_id(input int pool);
    if ($urandom_range(0, 19) == 0) return '0;
    if (pool == 0) return ITEM_W'($urandom_range(0, 65535));
    return ITEM_W'($urandom_range(1, pool));
  endfunction

  // Priorities: narrow band for ties, extremes, or anything
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    logic signed [PRIO_W-1:0] p;
    int                       sel;
    sel = $urandom_range(0, 7);
    if (sel < 4) begin
      p = $urandom_range(0, 6);
      p = p - 3;
    end else if (sel == 4) begin
      case ($urandom_range(0, 3))
        0: p = 32'sh8000_0000;
        1: p = 32'sh7FFF_FFFF;
        2: p = -1;
        default: p = 0;
      endcase
    end else begin
      p = $urandom();
    end
    return p;
  endfunction

  // Stimulus, reset and end of run
  initial begin
    int seq_sel;
    int pool;
    int seq_count;
    seq_count = 0;

    // directed: empty remove, null, extremes, duplicate, tie order, drain to empty
    add_remove();
    add_insert(16'h0000, 8'h5A, 32'sd7);
    add_insert(16'hFFFF, 8'hFF, 32'sh7FFF_FFFF);
    add_insert(16'h0001, 8'h00, 32'sh8000_0000);
    add_insert(16'h0002, 8'h11, 32'sd0);
    add_insert(16'hFFFF, 8'h22, 32'sd5);
    add_insert(16'h0003, 8'h33, 32'sd0);
    add_insert(16'h0004, 8'hA5, -32'sd1);
    add_insert(16'h8000, 8'h80, 32'sh7FFF_FFFF);
    repeat (7) add_remove();
    add_pause();

    // random: well-formed fill/drain sequences with random content, plus noise
    while (item_total < N_ITEMS) begin
      seq_sel = $urandom_range(0, 9);
      pool    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(20, 48);
      if (seq_sel < 4) begin
        repeat ($urandom_range(14, 22)) add_insert(pick_id(pool),
                                                   KIND_W'($urandom_range(0, 255)),
                                                   pick_prio());
        repeat ($urandom_range(4, 20)) add_remove();
      end else if (seq_sel < 7) begin
        repeat ($urandom_range(10, 30)) begin
          if ($urandom_range(0, 1) == 0) add_remove();
          else add_insert(pick_id(pool), KIND_W'($urandom_range(0, 255)), pick_prio());
        end
      end else if (seq_sel < 9) begin
        repeat ($urandom_range(10, 18)) add_remove();
      end else begin
        repeat ($urandom_range(5, 15)) begin
          if ($urandom_range(0, 2) == 0) add_remove();
          else add_insert($urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom_range(0, 65535)),
                          KIND_W'($urandom_range(0, 255)), $urandom());
        end
      end
      seq_count++;
      if (seq_count % 25 == 0) add_pause();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every transaction to be taken, then every result, then a quiet tail
    while (pending_ops.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (4 * DEPTH + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("stable_priority_queue test passed");
    end else begin
      $display("stable_priority_queue test failed");
    end
    $finish;
  end

  // Driver: hold a stalled transaction, otherwise load the next one or idle
  int gap_left    = 0;
  int sent_count  = 0;
  bit drv_idle_on = 1'b1;

  always @(posedge clk) begin
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_queue_op(cur_op));
        nxt_valid = 1'b0;
        sent_count++;
        if (sent_count % 64 == 0) drv_idle_on = 1'($urandom_range(0, 1));
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          if (pending_ops[0].pause) begin
            // hold off until every outstanding result is back
            if (expected_results.size() == 0) void'(pending_ops.pop_front());
          end else begin
            cur_op = pending_ops.pop_front();
            in_op           <= cur_op.op;
            in_item_id      <= cur_op.item_id;
            in_kind         <= cur_op.kind;
            in_priority_req <= cur_op.prio;
            nxt_valid = 1'b1;
            if (drv_idle_on && !in_tail_phase() && $urandom_range(0, 3) == 0)
              gap_left = $urandom_range(1, 10);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Monitor: check each result transaction and drive out_stall
  int results_seen = 0;
  int hold_left    = 0;
  int stall_left   = 0;
  bit mon_idle_on  = 1'b1;

  always @(posedge clk) begin
    queue_result_t want;
    logic          nxt_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", longint'(out_status), -1);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", longint'(out_status), longint'(want.status));
          if (out_count !== want.count)
            report_mismatch("count", longint'(out_count), longint'(want.count));
          if (out_item_id !== want.item_id)
            report_mismatch("item_id", longint'(out_item_id), longint'(want.item_id));
          if (out_kind !== want.kind)
            report_mismatch("kind", longint'(out_kind), longint'(want.kind));
          if (out_priority !== want.prio)
            report_mismatch("priority", longint'(out_priority), longint'(want.prio));
        end
        // long back-pressure so the block fills and stalls its input
        if (results_seen == 250 || results_seen == 1000) hold_left = LONG_HOLD;
        if (results_seen % 64 == 0) mon_idle_on = 1'($urandom_range(0, 1));
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = 1'b0;
        if (mon_idle_on && !in_tail_phase() && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 10) - 1;
          nxt_stall  = 1'b1;
        end
      end
      out_stall <= nxt_stall;
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("stable_priority_queue test failed");
      $finish;
    end
  end

  // Predicted store starts empty
  initial begin
    stored_count = 0;
    item_total   = 0;
    mismatches   = 0;
    cycle_count  = 0;
  end

endmodule

FILE: filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/stable_priority_queue.sv
rtl/core/spq_checker.sv
tb/sv/stable_priority_queue_tb.sv
